@@ design/flrp_pkg.sv @@
// ----------------------------------------------------------------------------
// flrp_pkg: shared types and constants of the flash log record placer
// Field widths, result kinds, error codes, register indexes, sequencer states
// and the request/response bundles of the shared remainder unit.
// ----------------------------------------------------------------------------
package flrp_pkg;

  // fixed sizes
  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned MAX_RECORD   = 1024;
  localparam int unsigned LEN_W        = 11;
  localparam int unsigned ADDR_W       = 32;
  localparam int unsigned PAGE_W       = 16;
  localparam int unsigned DVD_W        = ADDR_W + 1;
  localparam int unsigned ERASE_MAX    = 7;
  localparam int unsigned CNT_W        = $clog2(ERASE_MAX + 1);

  // result kinds
  localparam logic [1:0] KIND_ERASE  = 2'd0;
  localparam logic [1:0] KIND_PLACED = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_REGION     = 2'd1;
  localparam logic [1:0] ERR_LENGTH     = 2'd2;
  localparam logic [1:0] ERR_PAST_END   = 2'd3;

  // register indexes (word address bits)
  localparam logic [1:0] REG_REGION_START = 2'd0;
  localparam logic [1:0] REG_REGION_SIZE  = 2'd1;
  localparam logic [1:0] REG_PAGE_SIZE    = 2'd2;
  localparam logic [1:0] REG_RECORD_LIMIT = 2'd3;

  // reset values of the registers
  localparam logic [ADDR_W-1:0] RST_REGION_SIZE  = 32'd65536;
  localparam logic [PAGE_W-1:0] RST_PAGE_SIZE    = 16'd4096;
  localparam logic [LEN_W-1:0]  RST_RECORD_LIMIT = 11'd1024;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_SIZE,
    ST_DIV_SPAN,
    ST_WALK,
    ST_EMIT
  } state_t;

  // remainder unit request and response
  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [PAGE_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic              done;
    logic [PAGE_W-1:0] rem;
  } mod_rsp_t;

endpackage

@@ design/flrp_ifs.sv @@
// ----------------------------------------------------------------------------
// flrp_ifs: valid/ready channels of the flash log record placer
// Request channel carries a record length, result channel one result item.
// ----------------------------------------------------------------------------
interface flrp_in_if
  import flrp_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] record_length;

  modport source (output valid, output record_length, input ready);
  modport sink   (input valid, input record_length, output ready);
endinterface

interface flrp_out_if
  import flrp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [ADDR_W-1:0] page_or_header_addr;
  logic [ADDR_W-1:0] payload_addr;
  logic [ADDR_W-1:0] previous_addr;
  logic [ADDR_W-1:0] following_addr;
  logic              wrapped;
  logic [1:0]        error_code;
  logic              last;

  modport source (
    output valid, output kind, output page_or_header_addr, output payload_addr,
    output previous_addr, output following_addr, output wrapped,
    output error_code, output last, input ready
  );
  modport sink (
    input valid, input kind, input page_or_header_addr, input payload_addr,
    input previous_addr, input following_addr, input wrapped,
    input error_code, input last, output ready
  );
endinterface

@@ design/flrp_mod_unit.sv @@
// ----------------------------------------------------------------------------
// flrp_mod_unit: bit-serial remainder unit
// Restoring division, one dividend bit per cycle, remainder only. A start
// loads the operands; done pulses with the remainder after the last bit.
// ----------------------------------------------------------------------------
module flrp_mod_unit
  import flrp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mod_req_t req,
  output mod_rsp_t rsp
);

  localparam int unsigned STEP_W = $clog2(DVD_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [PAGE_W-1:0] dsr_r;
  logic [PAGE_W-1:0] rem_r;
  logic [PAGE_W-1:0] rem_nxt;
  logic [PAGE_W:0]   trial;

  // one restoring step: bring down the next bit, subtract if it fits
  always_comb begin
    trial = {rem_r, dvd_r[DVD_W-1]};
    if (trial >= {1'b0, dsr_r}) begin
      rem_nxt = PAGE_W'(trial - {1'b0, dsr_r});
    end else begin
      rem_nxt = trial[PAGE_W-1:0];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(DVD_W);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dsr_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

@@ design/flash_log_record_placer_top.sv @@
// ----------------------------------------------------------------------------
// flash_log_record_placer_top: places appended records in a circular log
// Checks the region settings, places the header, walks the header and data
// spans for page erases and then reports erases and the placement, or an error.
// ----------------------------------------------------------------------------
// Sequence of a placement: four remainder passes (region start, region size, header span,
// data span), a closing step for each span walk, a walk step per erase and a result transfer
// per item. Settings or length errors end after zero, one or two remainder passes.
// Throughput: one request at a time; the request channel is ready only when idle, from the cycle
// after the last result transfer.
// Reset: registers take their reset values, both record addresses clear to zero, idle.
module flash_log_record_placer_top
  import flrp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  flrp_in_if.sink            in_ch,
  flrp_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // configuration registers
  logic [ADDR_W-1:0] region_start_r;
  logic [ADDR_W-1:0] region_size_r;
  logic [PAGE_W-1:0] page_size_r;
  logic [LEN_W-1:0]  record_limit_r;

  // log state
  logic [ADDR_W-1:0] cur_r, cur_nxt;
  logic [ADDR_W-1:0] next_r, next_nxt;

  // request state
  state_t             state_r, state_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [ADDR_W-1:0]  hdr_r, hdr_nxt;
  logic [ADDR_W:0]    fol_r, fol_nxt;
  logic [ADDR_W-1:0]  end_r, end_nxt;
  logic               wrap_r, wrap_nxt;
  logic               span_data_r, span_data_nxt;
  logic [LEN_W-1:0]   span_len_r, span_len_nxt;
  logic [PAGE_W-1:0]  dist_r, dist_nxt;
  logic [ADDR_W+1:0]  ea_r, ea_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [CNT_W-1:0]   k_r, k_nxt;
  logic [1:0]         fin_kind_r, fin_kind_nxt;
  logic [1:0]         fin_err_r, fin_err_nxt;
  logic [ADDR_W-1:0]  eb_r [ERASE_MAX];
  logic               eb_we;
  logic [ADDR_W-1:0]  eb_wdata;

  mod_req_t mod_req;
  mod_rsp_t mod_rsp;

  logic              cfg_wr;
  logic              in_xfer;
  logic              out_xfer;
  logic              region_bad;
  logic              len_bad;
  logic [ADDR_W:0]   region_sum;
  logic [ADDR_W:0]   fol_here;
  logic [ADDR_W:0]   fol_wrap;
  logic [ADDR_W:0]   span_addr;
  logic [ADDR_W+2:0] ea_page_end;
  logic              last_item;

  flrp_mod_unit u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      REG_REGION_START: prdata = region_start_r;
      REG_REGION_SIZE:  prdata = region_size_r;
      REG_PAGE_SIZE:    prdata = {16'd0, page_size_r};
      REG_RECORD_LIMIT: prdata = {21'd0, record_limit_r};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_start_r <= '0;
      region_size_r  <= RST_REGION_SIZE;
      page_size_r    <= RST_PAGE_SIZE;
      record_limit_r <= RST_RECORD_LIMIT;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_REGION_START: region_start_r <= pwdata;
        REG_REGION_SIZE:  region_size_r  <= pwdata;
        REG_PAGE_SIZE:    page_size_r    <= pwdata[PAGE_W-1:0];
        REG_RECORD_LIMIT: record_limit_r <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // handshakes
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_xfer    = out_ch.valid && out_ch.ready;
  assign last_item   = (k_r == n_r);

  // settings checks that need no remainder
  assign region_sum = {1'b0, region_start_r} + {1'b0, region_size_r};
  assign region_bad = (region_size_r == '0) || region_sum[ADDR_W] ||
                      ({21'd0, record_limit_r} + HEADER_BYTES > region_size_r);
  assign len_bad    = (len_r == '0) || (len_r > LEN_W'(MAX_RECORD)) ||
                      (len_r > record_limit_r);

  // candidate placements
  assign fol_here = {1'b0, next_r} + (ADDR_W + 1)'(HEADER_BYTES) + {22'd0, len_r};
  assign fol_wrap = {1'b0, region_start_r} + (ADDR_W + 1)'(HEADER_BYTES) +
                    {22'd0, len_r};

  // span start and boundary look-ahead
  assign span_addr   = {1'b0, hdr_r} +
                       (span_data_r ? (ADDR_W + 1)'(HEADER_BYTES) : '0);
  assign ea_page_end = {1'b0, ea_r} + {19'd0, page_size_r};

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    hdr_nxt       = hdr_r;
    fol_nxt       = fol_r;
    end_nxt       = end_r;
    wrap_nxt      = wrap_r;
    span_data_nxt = span_data_r;
    span_len_nxt  = span_len_r;
    dist_nxt      = dist_r;
    ea_nxt        = ea_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    fin_kind_nxt  = fin_kind_r;
    fin_err_nxt   = fin_err_r;
    cur_nxt       = cur_r;
    next_nxt      = next_r;
    eb_we         = 1'b0;
    eb_wdata      = ea_r[ADDR_W-1:0];
    mod_req.start    = 1'b0;
    mod_req.dividend = {1'b0, region_start_r};
    mod_req.divisor  = page_size_r;

    case (state_r)
      ST_IDLE: begin
        if (cfg_wr && (paddr[3:2] == REG_REGION_START)) begin
          cur_nxt  = pwdata;
          next_nxt = pwdata;
        end
        if (in_xfer) begin
          len_nxt      = in_ch.record_length;
          n_nxt        = '0;
          k_nxt        = '0;
          wrap_nxt     = 1'b0;
          fin_kind_nxt = KIND_ERROR;
          fin_err_nxt  = ERR_REGION;
          if (page_size_r == '0) begin
            state_nxt = ST_EMIT;
          end else begin
            mod_req.start = 1'b1;
            state_nxt     = ST_DIV_START;
          end
        end
      end

      // region start must sit on a page boundary
      ST_DIV_START: begin
        if (mod_rsp.done) begin
          if (mod_rsp.rem != '0) begin
            state_nxt = ST_EMIT;
          end else begin
            mod_req.start    = 1'b1;
            mod_req.dividend = {1'b0, region_size_r};
            state_nxt        = ST_DIV_SIZE;
          end
        end
      end

      // region size check, length check, then header placement
      ST_DIV_SIZE: begin
        if (mod_rsp.done) begin
          if ((mod_rsp.rem != '0) || region_bad) begin
            state_nxt = ST_EMIT;
          end else if (len_bad) begin
            fin_err_nxt = ERR_LENGTH;
            state_nxt   = ST_EMIT;
          end else begin
            end_nxt       = region_sum[ADDR_W-1:0];
            span_data_nxt = 1'b0;
            span_len_nxt  = LEN_W'(HEADER_BYTES);
            mod_req.start = 1'b1;
            state_nxt     = ST_DIV_SPAN;
            if (fol_here > region_sum) begin
              hdr_nxt          = region_start_r;
              fol_nxt          = fol_wrap;
              wrap_nxt         = 1'b1;
              eb_we            = 1'b1;
              eb_wdata         = region_start_r;
              n_nxt            = CNT_W'(1);
              mod_req.dividend = {1'b0, region_start_r};
            end else begin
              hdr_nxt          = next_r;
              fol_nxt          = fol_here;
              mod_req.dividend = {1'b0, next_r};
            end
          end
        end
      end

      // distance to the first boundary of the span
      ST_DIV_SPAN: begin
        if (mod_rsp.done) begin
          dist_nxt  = page_size_r - mod_rsp.rem;
          ea_nxt    = {1'b0, span_addr} + {18'd0, page_size_r - mod_rsp.rem};
          state_nxt = ST_WALK;
        end
      end

      // one page boundary per cycle
      ST_WALK: begin
        if (({5'd0, span_len_r} < dist_r) ||
            ((ea_r == {2'b0, end_r}) && ({5'd0, span_len_r} == dist_r))) begin
          if (!span_data_r) begin
            span_data_nxt    = 1'b1;
            span_len_nxt     = len_r;
            mod_req.start    = 1'b1;
            mod_req.dividend = {1'b0, hdr_r} + (ADDR_W + 1)'(HEADER_BYTES);
            state_nxt        = ST_DIV_SPAN;
          end else begin
            fin_kind_nxt = KIND_PLACED;
            fin_err_nxt  = ERR_NONE;
            state_nxt    = ST_EMIT;
          end
        end else if (ea_page_end > {3'b0, end_r}) begin
          fin_kind_nxt = KIND_ERROR;
          fin_err_nxt  = ERR_PAST_END;
          state_nxt    = ST_EMIT;
        end else if (n_r == CNT_W'(ERASE_MAX)) begin
          n_nxt        = '0;
          fin_kind_nxt = KIND_ERROR;
          fin_err_nxt  = ERR_REGION;
          state_nxt    = ST_EMIT;
        end else begin
          eb_we        = 1'b1;
          n_nxt        = n_r + 1'b1;
          span_len_nxt = span_len_r - dist_r[LEN_W-1:0];
          dist_nxt     = page_size_r;
          ea_nxt       = ea_page_end[ADDR_W+1:0];
        end
      end

      // buffered erases first, then the closing result
      ST_EMIT: begin
        if (out_xfer) begin
          if (last_item) begin
            if (fin_kind_r == KIND_PLACED) begin
              cur_nxt  = hdr_r;
              next_nxt = fol_r[ADDR_W-1:0];
            end
            state_nxt = ST_IDLE;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cur_r   <= '0;
      next_r  <= '0;
      n_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      next_r  <= next_nxt;
      n_r     <= n_nxt;
      k_r     <= k_nxt;
    end
  end

  // request payload registers
  always_ff @(posedge clk) begin
    len_r       <= len_nxt;
    hdr_r       <= hdr_nxt;
    fol_r       <= fol_nxt;
    end_r       <= end_nxt;
    wrap_r      <= wrap_nxt;
    span_data_r <= span_data_nxt;
    span_len_r  <= span_len_nxt;
    dist_r      <= dist_nxt;
    ea_r        <= ea_nxt;
    fin_kind_r  <= fin_kind_nxt;
    fin_err_r   <= fin_err_nxt;
    if (eb_we) begin
      eb_r[n_r] <= eb_wdata;
    end
  end

  // result channel
  always_comb begin
    out_ch.valid               = (state_r == ST_EMIT);
    out_ch.kind                = KIND_ERASE;
    out_ch.page_or_header_addr = '0;
    out_ch.payload_addr        = '0;
    out_ch.previous_addr       = '0;
    out_ch.following_addr      = '0;
    out_ch.wrapped             = 1'b0;
    out_ch.error_code          = ERR_NONE;
    out_ch.last                = 1'b0;
    if (!last_item) begin
      out_ch.page_or_header_addr = eb_r[k_r];
    end else begin
      out_ch.kind       = fin_kind_r;
      out_ch.error_code = fin_err_r;
      out_ch.last       = 1'b1;
      if (fin_kind_r == KIND_PLACED) begin
        out_ch.page_or_header_addr = hdr_r;
        out_ch.payload_addr        = hdr_r + ADDR_W'(HEADER_BYTES);
        out_ch.previous_addr       = cur_r;
        out_ch.following_addr      = fol_r[ADDR_W-1:0];
        out_ch.wrapped             = wrap_r;
      end
    end
  end

endmodule
